/* src/assert_macros.svh */
// Assertion macros used by the checker file of the random-number unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, muted while reset is low.
`define AFX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle, muted while reset is low.
`define AFX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle, active through reset as well.
`define AFX_ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/afx_pkg.sv */
// Types, constants and the xorshift step shared by the random-number unit.
package afx_pkg;

    localparam int MAX_WINDOWS  = 3;
    localparam int NUM_WINDOWS  = 3;
    localparam int RING_DEPTH   = 64;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int IDX_W        = 6;
    localparam int ADDR_W       = 32;
    localparam int VALUE_W      = 16;
    localparam int CNT_W        = 32;
    localparam int RC_W         = 2;
    localparam int PADDR_W      = 5;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 112;

    typedef enum logic {
        ACT_DRAW = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        REG_SEED        = 3'd0,
        REG_RANGE_COUNT = 3'd1,
        REG_WIN0_LOW    = 3'd2,
        REG_WIN0_HIGH   = 3'd3,
        REG_WIN1_LOW    = 3'd4,
        REG_WIN1_HIGH   = 3'd5,
        REG_WIN2_LOW    = 3'd6,
        REG_WIN2_HIGH   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [RC_W-1:0]                     range_count;
        logic [NUM_WINDOWS-1:0][ADDR_W-1:0]  win_low;
        logic [NUM_WINDOWS-1:0][ADDR_W-1:0]  win_high;
    } t_cfg;

    typedef struct packed {
        logic               hit;
        logic               miss;
        logic [CNT_W-1:0]   next_state;
        logic [VALUE_W-1:0] value;
    } t_draw;

    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [ADDR_W-1:0]  wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_req;

    // One xorshift32 step with shifts 13, 17, 5.
    function automatic logic [CNT_W-1:0] xorshift32(input logic [CNT_W-1:0] s);
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        a = s ^ (s << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

/* src/afx_cfg_regs.sv */
// Configuration register file behind the APB-style port.
module afx_cfg_regs
    import afx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [PADDR_W-1:0]  i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_seed_wr,
    output logic [CNT_W-1:0]    o_seed,
    output t_cfg                o_cfg
);

    logic [CNT_W-1:0] r_seed;
    t_cfg             r_cfg;
    logic             wr_en;
    t_reg_idx         idx;

    assign idx       = t_reg_idx'(i_paddr[PADDR_W-1:2]);
    assign wr_en     = i_psel & i_penable & i_pwrite;
    assign o_seed_wr = wr_en && (idx == REG_SEED);
    assign o_seed    = i_pwdata;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_cfg  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_SEED:        r_seed              <= i_pwdata;
                REG_RANGE_COUNT: r_cfg.range_count   <= i_pwdata[RC_W-1:0];
                REG_WIN0_LOW:    r_cfg.win_low[0]    <= i_pwdata;
                REG_WIN0_HIGH:   r_cfg.win_high[0]   <= i_pwdata;
                REG_WIN1_LOW:    r_cfg.win_low[1]    <= i_pwdata;
                REG_WIN1_HIGH:   r_cfg.win_high[1]   <= i_pwdata;
                REG_WIN2_LOW:    r_cfg.win_low[2]    <= i_pwdata;
                REG_WIN2_HIGH:   r_cfg.win_high[2]   <= i_pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SEED:        o_prdata = r_seed;
            REG_RANGE_COUNT: o_prdata = {{(32-RC_W){1'b0}}, r_cfg.range_count};
            REG_WIN0_LOW:    o_prdata = r_cfg.win_low[0];
            REG_WIN0_HIGH:   o_prdata = r_cfg.win_high[0];
            REG_WIN1_LOW:    o_prdata = r_cfg.win_low[1];
            REG_WIN1_HIGH:   o_prdata = r_cfg.win_high[1];
            REG_WIN2_LOW:    o_prdata = r_cfg.win_low[2];
            REG_WIN2_HIGH:   o_prdata = r_cfg.win_high[2];
        endcase
    end

endmodule

/* src/afx_draw_unit.sv */
// Window match and xorshift step for one draw request.
module afx_draw_unit
    import afx_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_action           i_action,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [CNT_W-1:0]  i_state,
    output t_draw             o_draw
);

    logic [NUM_WINDOWS-1:0] win_hit;
    logic                   match;
    logic                   armed;

    // Each window is half-open; an empty window never matches.
    always_comb begin
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            win_hit[w] = (w < MAX_WINDOWS)
                      && (32'(w) < 32'(i_cfg.range_count))
                      && (i_addr >= i_cfg.win_low[w])
                      && (i_addr <  i_cfg.win_high[w]);
        end
    end

    assign match = |win_hit;
    assign armed = (i_action == ACT_DRAW) && (i_state != '0);

    always_comb begin
        o_draw.next_state = xorshift32(i_state);
        o_draw.hit        = armed & match;
        o_draw.miss       = armed & ~match;
        o_draw.value      = o_draw.hit ? o_draw.next_state[CNT_W-1 -: VALUE_W] : '0;
    end

endmodule

/* src/afx_caller_ring.sv */
// Caller ring memory with per-entry valid bits and a registered read port.
module afx_caller_ring
    import afx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ring_req         i_req,
    output logic [ADDR_W-1:0] o_rd_data
);

    logic [ADDR_W-1:0]     r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_valid;
    logic [ADDR_W-1:0]     r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        // An entry never written reads as zero.
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

endmodule

/* src/address_filtered_xorshift_rng_unit.sv */
// Top level of the address-filtered xorshift32 random-number unit.
//
//   port group   dir  tdata / data fields (low bit up)                 tuser
//   request      in   caller_address[31:0] ring_index[37:32] 0[39:38]  action
//   result       out  random_value[15:0] hit_total[47:16]              hit
//                     miss_total[79:48] ring_entry[111:80]
//   config       in   APB write/read, register i at byte address 4*i   -
//
// One request enters per clock into the input register while the result
// side is not stalled; its result is then loaded into the result register,
// from which it leaves. The critical path is the three window compares
// feeding the hit decision and the state/counter updates.
// Reset is synchronous and active low; it clears all control state,
// the counters, the generator state and the ring valid bits.
// A stalled result holds in the result register while the input register
// keeps one more request; acceptance stops only when both are full.
module address_filtered_xorshift_rng_unit
    import afx_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // caller_address, ring_index, zero pad
    input  logic                   i_s_tuser,   // action
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // random_value, hit_total, miss_total,
                                                // ring_entry
    output logic                   o_m_tuser,   // hit
    // configuration
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [PADDR_W-1:0]     i_paddr,
    input  logic [31:0]            i_pwdata,
    output logic [31:0]            o_prdata,
    output logic                   o_pready
);

    // Configuration
    t_cfg             cfg;
    logic             seed_wr;
    logic [CNT_W-1:0] seed;

    afx_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_seed_wr (seed_wr),
        .o_seed    (seed),
        .o_cfg     (cfg)
    );

    assign o_pready = 1'b1;

    // Input register
    logic              r_in_valid;
    t_action           r_in_action;
    logic [ADDR_W-1:0] r_in_addr;
    logic [IDX_W-1:0]  r_in_idx;

    // Result register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [VALUE_W-1:0] r_out_value;
    logic [CNT_W-1:0]   r_out_hit_total;
    logic [CNT_W-1:0]   r_out_miss_total;
    logic               r_out_is_read;

    // Architectural state
    logic [CNT_W-1:0] r_state;
    logic [CNT_W-1:0] r_hit_cnt;
    logic [CNT_W-1:0] r_miss_cnt;
    logic [CNT_W-1:0] n_hit_cnt;
    logic [CNT_W-1:0] n_miss_cnt;

    logic              advance;
    logic              in_take;
    t_draw             draw;
    t_ring_req         ring_req;
    logic [ADDR_W-1:0] ring_rd_data;

    // Move the held request into the result register when that frees up.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    afx_draw_unit u_draw (
        .i_cfg    (cfg),
        .i_action (r_in_action),
        .i_addr   (r_in_addr),
        .i_state  (r_state),
        .o_draw   (draw)
    );

    assign n_hit_cnt  = r_hit_cnt  + CNT_W'(draw.hit);
    assign n_miss_cnt = r_miss_cnt + CNT_W'(draw.miss);

    // Log the caller at hit_count mod depth; reads index mod depth too.
    always_comb begin
        ring_req.wr_en   = advance && draw.hit;
        ring_req.wr_addr = r_hit_cnt[RING_AW-1:0];
        ring_req.wr_data = r_in_addr;
        ring_req.rd_en   = advance && (r_in_action == ACT_READ);
        ring_req.rd_addr = r_in_idx[RING_AW-1:0];
    end

    afx_caller_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ring_req),
        .o_rd_data (ring_rd_data)
    );

    // Input register: control with reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= t_action'(i_s_tuser);
            // Drop bit 0 of the caller address.
            r_in_addr   <= {i_s_tdata[ADDR_W-1:1], 1'b0};
            r_in_idx    <= i_s_tdata[ADDR_W +: IDX_W];
        end
    end

    // Generator state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
        end else begin
            if (seed_wr) begin
                r_state <= seed;
            end else if (advance && draw.hit) begin
                r_state <= draw.next_state;
            end
            if (advance) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hit        <= draw.hit;
            r_out_value      <= draw.value;
            r_out_hit_total  <= n_hit_cnt;
            r_out_miss_total <= n_miss_cnt;
            r_out_is_read    <= (r_in_action == ACT_READ);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {r_out_is_read ? ring_rd_data : {ADDR_W{1'b0}},
                         r_out_miss_total,
                         r_out_hit_total,
                         r_out_value};

endmodule

/* src/afx_checker.sv */
// Port-level checker for the random-number unit and its bind statement.
`include "assert_macros.svh"

module afx_checker
    import afx_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser,
    input logic                   o_pready
);

    // A stalled result keeps its payload.
    `AFX_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // Reset empties the result register.
    `AFX_ASSERT_NEXT_RST(a_reset_empty, i_clk, !i_rst_n, !o_m_tvalid)

    // A result without a hit carries a zero random value.
    `AFX_ASSERT_SAME(a_nohit_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata[VALUE_W-1:0] == '0)

    // A hit is never a ring read, so it carries a zero ring entry.
    `AFX_ASSERT_SAME(a_hit_no_entry, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[OUT_TDATA_W-1 -: ADDR_W] == '0 && o_pready)

endmodule

bind address_filtered_xorshift_rng_unit afx_checker u_afx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_pready   (o_pready)
);

/* bench/address_filtered_xorshift_rng_unit_tb.sv */
// Self-checking bench for the address-filtered xorshift32 random-number unit.
module address_filtered_xorshift_rng_unit_tb;
    import afx_pkg::*;

    // Quiet cycles (no request or result moving) before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Chance, in percent, that either side idles in a given cycle.
    localparam int IDLE_PCT     = 28;
    // Cycles to let the two pipeline stages empty before touching registers.
    localparam int DRAIN_CYCLES = 4;
    localparam int NUM_PHASES   = 8;
    localparam int PAD_W        = IN_TDATA_W - ADDR_W - IDX_W;

    // One result as the unit reports it.
    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [ADDR_W-1:0]  entry;
    } t_outcome;

    // Directed rows: a register write, a request checked against the
    // predictor, or a request whose result is typed in by hand.
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_REQ,
        ROW_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_reg_idx           reg_sel;
        logic [31:0]        reg_val;
        t_action            act;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   idx;
        t_outcome           typed;
    } t_row;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;   // caller_address, ring_index, zero pad
    logic                   i_s_tuser  = 1'b0; // action
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // random_value, hit_total, miss_total,
                                               // ring_entry
    logic                   o_m_tuser;         // hit
    logic                   i_psel     = 1'b0;
    logic                   i_penable  = 1'b0;
    logic                   i_pwrite   = 1'b0;
    logic [PADDR_W-1:0]     i_paddr    = '0;
    logic [31:0]            i_pwdata   = '0;
    logic [31:0]            o_prdata;
    logic                   o_pready;

    // Predictor state: generator, counters, caller log and the register copy.
    logic [CNT_W-1:0]  gen_state;
    logic [CNT_W-1:0]  hits_seen;
    logic [CNT_W-1:0]  misses_seen;
    logic [ADDR_W-1:0] caller_log [RING_DEPTH];
    logic [RC_W-1:0]   windows_used;
    logic [ADDR_W-1:0] win_lo [NUM_WINDOWS];
    logic [ADDR_W-1:0] win_hi [NUM_WINDOWS];

    t_outcome due_results [$];
    bit       failed = 1'b0;
    bit       calm   = 1'b0;   // when set, neither side idles
    int       quiet_cycles = 0;

    address_filtered_xorshift_rng_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // Start low so the first rising edge comes half a period in.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Work out the result of one accepted request and advance the predictor.
    function automatic t_outcome serve_request(t_action act, logic [ADDR_W-1:0] addr,
                                               logic [IDX_W-1:0] idx);
        t_outcome          res;
        logic [ADDR_W-1:0] caller;
        logic [CNT_W-1:0]  s;
        bit                matched;
        res     = '0;
        caller  = {addr[ADDR_W-1:1], 1'b0};   // drop bit 0 of the caller
        matched = 1'b0;
        // Check only windows below both the programmed count and the build limit;
        // an empty window (low >= high) never matches.
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            if (w < MAX_WINDOWS && w < int'(windows_used) &&
                caller >= win_lo[w] && caller < win_hi[w])
                matched = 1'b1;
        end
        if (act == ACT_READ) begin
            res.entry = caller_log[idx % RING_DEPTH];
        end else if (gen_state != '0) begin
            if (!matched) begin
                misses_seen = misses_seen + 1'b1;
            end else begin
                s = gen_state;
                s = s ^ (s << 13);
                s = s ^ (s >> 17);
                s = s ^ (s << 5);
                gen_state = s;
                caller_log[hits_seen[RING_AW-1:0]] = caller;
                hits_seen = hits_seen + 1'b1;
                res.hit   = 1'b1;
                res.value = s[CNT_W-1:CNT_W-VALUE_W];
            end
        end
        // A zero generator state leaves everything untouched.
        res.hit_total  = hits_seen;
        res.miss_total = misses_seen;
        return res;
    endfunction

    function automatic t_row reg_row(t_reg_idx r, logic [31:0] v);
        t_row row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_sel = r;
        row.reg_val = v;
        return row;
    endfunction

    function automatic t_row req_row(t_action act, logic [ADDR_W-1:0] addr,
                                     logic [IDX_W-1:0] idx);
        t_row row;
        row      = '0;
        row.kind = ROW_REQ;
        row.act  = act;
        row.addr = addr;
        row.idx  = idx;
        return row;
    endfunction

    function automatic t_row typed_row(t_action act, logic [ADDR_W-1:0] addr,
                                       logic [IDX_W-1:0] idx, t_outcome res);
        t_row row;
        row       = req_row(act, addr, idx);
        row.kind  = ROW_TYPED;
        row.typed = res;
        return row;
    endfunction

    // Offer one request, idling at random first, and log its expected result
    // at the edge where it is taken.
    task automatic send_request(t_action act, logic [ADDR_W-1:0] addr,
                                logic [IDX_W-1:0] idx, bit use_typed, t_outcome typed);
        t_outcome want;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{PAD_W{1'b0}}, idx, addr};
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        want = serve_request(act, addr, idx);
        due_results.push_back(use_typed ? typed : want);
    endtask

    // Hold off requests until every result is back and the pipeline is empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // access edge, so mirror it into the predictor there.
    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {r, 2'b00};
        i_pwdata  <= v;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        case (r)
            REG_SEED:        gen_state    = v;
            REG_RANGE_COUNT: windows_used = v[RC_W-1:0];
            REG_WIN0_LOW:    win_lo[0]    = v;
            REG_WIN0_HIGH:   win_hi[0]    = v;
            REG_WIN1_LOW:    win_lo[1]    = v;
            REG_WIN1_HIGH:   win_hi[1]    = v;
            REG_WIN2_LOW:    win_lo[2]    = v;
            REG_WIN2_HIGH:   win_hi[2]    = v;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Compare each result taken with the oldest expectation, then pick the
    // next cycle's ready at random.
    always @(posedge i_clk) begin : result_check
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hit        = o_m_tuser;
            got.value      = o_m_tdata[VALUE_W-1:0];
            got.hit_total  = o_m_tdata[VALUE_W +: CNT_W];
            got.miss_total = o_m_tdata[VALUE_W+CNT_W +: CNT_W];
            got.entry      = o_m_tdata[VALUE_W+2*CNT_W +: ADDR_W];
            if (due_results.size() == 0) begin
                $display("%0t: result with no request pending, expected none, got %h",
                         $time, got);
                failed = 1'b1;
            end else begin
                want = due_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(got.hit));
                check_field("random_value", 32'(want.value), 32'(got.value));
                check_field("hit_total", want.hit_total, got.hit_total);
                check_field("miss_total", want.miss_total, got.miss_total);
                check_field("ring_entry", want.entry, got.entry);
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run when neither stream moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("address_filtered_xorshift_rng_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_row              steps [$];
        t_row              row;
        t_action           act;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] span;
        logic [31:0]       seed;
        int                items;
        int                pick;
        int                w;
        bit                busy;

        gen_state    = '0;
        hits_seen    = '0;
        misses_seen  = '0;
        windows_used = '0;
        foreach (caller_log[k]) caller_log[k] = '0;
        foreach (win_lo[k]) begin
            win_lo[k] = '0;
            win_hi[k] = '0;
        end

        steps = '{
            // Out of reset the seed is zero: the generator is off and the log is clear.
            typed_row(ACT_DRAW, 32'hFFFF_FFFF, 6'd0, '0),
            typed_row(ACT_READ, 32'h0000_0000, 6'd63, '0),
            typed_row(ACT_READ, 32'hFFFF_FFFF, 6'd0, '0),
            // Window 0 low end, window 1 up to the top address, window 2 empty.
            reg_row(REG_WIN0_LOW,  32'h0000_0000),
            reg_row(REG_WIN0_HIGH, 32'h0000_0100),
            reg_row(REG_WIN1_LOW,  32'h8000_0000),
            reg_row(REG_WIN1_HIGH, 32'hFFFF_FFFF),
            reg_row(REG_WIN2_LOW,  32'h0000_0200),
            reg_row(REG_WIN2_HIGH, 32'h0000_0200),
            reg_row(REG_RANGE_COUNT, 32'd3),
            reg_row(REG_SEED, 32'hFFFF_FFFF),
            req_row(ACT_DRAW, 32'h0000_0000, 6'd0),
            req_row(ACT_DRAW, 32'h0000_0101, 6'd63),   // upper bound is exclusive
            req_row(ACT_DRAW, 32'h0000_00FF, 6'd0),    // bit 0 dropped, lands at 0xFE
            req_row(ACT_DRAW, 32'hFFFF_FFFF, 6'd0),    // 0xFFFFFFFE still inside
            req_row(ACT_DRAW, 32'h8000_0000, 6'd0),
            req_row(ACT_DRAW, 32'h0000_0200, 6'd0),    // empty window matches nothing
            req_row(ACT_DRAW, 32'h7FFF_FFFF, 6'd0),
            req_row(ACT_READ, 32'h0000_0000, 6'd0),
            req_row(ACT_READ, 32'h0000_0000, 6'd1),
            req_row(ACT_READ, 32'hFFFF_FFFF, 6'd3),
            // Window 2 made real but left outside the programmed count.
            reg_row(REG_WIN2_HIGH, 32'h0000_0300),
            reg_row(REG_RANGE_COUNT, 32'd2),
            req_row(ACT_DRAW, 32'h0000_0250, 6'd0),
            reg_row(REG_RANGE_COUNT, 32'd3),
            req_row(ACT_DRAW, 32'h0000_0250, 6'd0),
            // No windows at all: every draw is a miss.
            reg_row(REG_RANGE_COUNT, 32'd0),
            req_row(ACT_DRAW, 32'h0000_0000, 6'd0),
            // Smallest live seed.
            reg_row(REG_SEED, 32'd1),
            reg_row(REG_RANGE_COUNT, 32'd1),
            req_row(ACT_DRAW, 32'h0000_0000, 6'd0),
            req_row(ACT_DRAW, 32'h0000_0010, 6'd0),
            // Turn the generator off again: draws count nothing.
            reg_row(REG_SEED, 32'd0),
            req_row(ACT_DRAW, 32'h0000_0000, 6'd0),
            req_row(ACT_READ, 32'h0000_0000, 6'd4)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: drain before each group of register writes.
        busy = 1'b0;
        foreach (steps[i]) begin
            row = steps[i];
            if (row.kind == ROW_REG) begin
                if (busy) settle();
                busy = 1'b0;
                write_reg(row.reg_sel, row.reg_val);
            end else begin
                send_request(row.act, row.addr, row.idx, row.kind == ROW_TYPED, row.typed);
                busy = 1'b1;
            end
        end

        // Random part: each phase reprograms everything while idle, then runs
        // a stream of draws and reads aimed mostly inside the active windows.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            calm = (phase == 2);
            write_reg(REG_RANGE_COUNT, (phase == 4) ? 32'd0 : 32'(phase % 3 + 1));
            for (w = 0; w < NUM_WINDOWS; w++) begin
                pick = $urandom_range(9);
                lo   = $urandom;
                if (pick == 0) begin
                    // Whole address space.
                    lo = '0;
                    hi = '1;
                end else if (pick == 1) begin
                    // Empty: high at or below low.
                    hi = lo - $urandom_range(16);
                end else if (pick == 2) begin
                    hi = $urandom;
                end else begin
                    span = $urandom_range(1, 1 << 24);
                    hi   = (lo > '1 - span) ? '1 : lo + span;
                end
                write_reg(t_reg_idx'(REG_WIN0_LOW + 2 * w), lo);
                write_reg(t_reg_idx'(REG_WIN0_HIGH + 2 * w), hi);
            end
            case (phase)
                0:       seed = 32'hFFFF_FFFF;
                1:       seed = 32'd1;
                5:       seed = 32'd0;
                default: begin
                    seed = $urandom;
                    if (seed == '0) seed = 32'hA5A5_0000;
                end
            endcase
            write_reg(REG_SEED, seed);

            // A disabled generator ignores draws, so keep that phase short.
            items = (phase == 5) ? 20 : 118;
            for (int n = 0; n < items; n++) begin
                act  = ($urandom_range(99) < 25) ? ACT_READ : ACT_DRAW;
                pick = $urandom_range(99);
                w    = (windows_used != '0) ? $urandom_range(int'(windows_used) - 1) : 0;
                if (pick < 60 && win_lo[w] < win_hi[w]) begin
                    addr = win_lo[w] + ($urandom % (win_hi[w] - win_lo[w]));
                end else if (pick < 72) begin
                    // Hit the window edges and just past them.
                    case ($urandom_range(3))
                        0:       addr = win_lo[w];
                        1:       addr = win_hi[w];
                        2:       addr = win_hi[w] - 1'b1;
                        default: addr = win_lo[w] - 1'b1;
                    endcase
                end else begin
                    addr = $urandom;
                end
                send_request(act, addr, IDX_W'($urandom_range(RING_DEPTH - 1)), 1'b0, '0);
            end
        end

        settle();
        if (failed)
            $display("address_filtered_xorshift_rng_unit_tb NOT OK");
        else
            $display("address_filtered_xorshift_rng_unit_tb OK");
        $finish;
    end

endmodule

/* address_filtered_xorshift_rng_unit.f */
+incdir+src
src/afx_pkg.sv
src/afx_cfg_regs.sv
src/afx_draw_unit.sv
src/afx_caller_ring.sv
src/address_filtered_xorshift_rng_unit.sv
src/afx_checker.sv
bench/address_filtered_xorshift_rng_unit_tb.sv
